### rtl/stl_pkg.sv
// ---------------------------------------------------------------------------
// stl_pkg - shared types and constants of the sorted task list
// Entry format, operation and status codes, cell control bundle.
// ---------------------------------------------------------------------------
package stl_pkg;

	localparam int unsigned ID_W            = 4;
	localparam int unsigned KEY_W           = 32;
	localparam int unsigned ID_COUNT        = 16;
	localparam int unsigned NUM_ENTRIES_DEF = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_LISTED     = 2'd2,
		ST_NOT_LISTED = 2'd3
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

### rtl/stl_in_if.sv
// ---------------------------------------------------------------------------
// stl_in_if - operation channel of the sorted task list
// Valid/ready channel carrying one insert or delete operation per beat.
// ---------------------------------------------------------------------------
interface stl_in_if;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [stl_pkg::ID_W-1:0]  entry_id;
	logic [stl_pkg::KEY_W-1:0] sort_key;

	modport source (output valid, output op, output entry_id, output sort_key, input ready);
	modport sink   (input valid, input op, input entry_id, input sort_key, output ready);

endinterface

### rtl/stl_out_if.sv
// ---------------------------------------------------------------------------
// stl_out_if - result channel of the sorted task list
// Valid/ready channel carrying count, empty flag, head entry and status.
// ---------------------------------------------------------------------------
interface stl_out_if #(
	parameter int unsigned CNT_W = 5
);

	logic                     valid;
	logic                     ready;
	logic [CNT_W-1:0]          entry_count;
	logic                     list_empty;
	logic [stl_pkg::ID_W-1:0]  head_id;
	logic [stl_pkg::KEY_W-1:0] head_key;
	logic [1:0]               status;

	modport source (output valid, output entry_count, output list_empty, output head_id,
		output head_key, output status, input ready);
	modport sink   (input valid, input entry_count, input list_empty, input head_id,
		input head_key, input status, output ready);

endinterface

### rtl/stl_cell.sv
// ---------------------------------------------------------------------------
// stl_cell - one slot of the sorted chain
// Holds one entry; on insert takes the new entry or the left neighbor's,
// on delete takes the right neighbor's from the deleted id's slot onward.
// ---------------------------------------------------------------------------
module stl_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stl_pkg::cell_ctrl_t ctrl,
	input  stl_pkg::entry_t     left_q,
	input  logic                left_take,
	input  stl_pkg::entry_t     right_q,
	input  logic                shift_in,
	output logic                take,
	output logic                shift_out,
	output stl_pkg::entry_t     cur,
	output stl_pkg::entry_t     nxt
);

	stl_pkg::entry_t entry_q;
	logic            match;

	// new entry lands at or before this slot: slot empty or its key larger
	assign take      = !entry_q.valid || (entry_q.key > ctrl.key);
	assign match     = entry_q.valid && (entry_q.id == ctrl.id);
	assign shift_out = shift_in || match;
	assign cur       = entry_q;

	always_comb begin
		nxt = entry_q;
		if (ctrl.ins_en && take) begin
			if (left_take) begin
				nxt = left_q;
			end else begin
				nxt.valid = 1'b1;
				nxt.id    = ctrl.id;
				nxt.key   = ctrl.key;
			end
		end else if (ctrl.del_en && shift_out) begin
			nxt = right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= nxt;
		end
	end

endmodule

### rtl/sorted_task_list_core.sv
// ---------------------------------------------------------------------------
// sorted_task_list_core - stable sorted task list as a chain of slot cells
// Keeps up to NUM_ENTRIES entries in ascending key order, FIFO among equal keys.
// ---------------------------------------------------------------------------
// One operation is taken per clock and its result beat appears on rsp in the
// next cycle; a new operation is taken while the previous result is still
// waiting, as long as the result register is free or being drained that
// cycle. This speed comes from the cell chain: every slot compares the
// new key against its own in parallel and the whole row shifts right (insert)
// or left (delete) all at once, so no search loop exists. The delete
// locate bit ripples through the row, one OR gate per cell. An insert whose
// id is already listed reports "already listed" and an insert into a full
// list reports "list full"; both leave the list untouched. A delete of an id
// that is not listed reports "not listed". The all-ones key never compares
// larger than a stored key, so it always lands at the tail. Head fields read
// zero when the list is empty. Reset clears all slots at once.
// ---------------------------------------------------------------------------
module sorted_task_list_core #(
	parameter int unsigned NUM_ENTRIES = stl_pkg::NUM_ENTRIES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	stl_in_if.sink   req,
	stl_out_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

	// chain signals; index NUM_ENTRIES stands for the empty slot past the end
	stl_pkg::entry_t         cur [NUM_ENTRIES+1];
	stl_pkg::entry_t         nxt [NUM_ENTRIES];
	logic [NUM_ENTRIES:0]    take;
	logic [NUM_ENTRIES:0]    shift;
	stl_pkg::cell_ctrl_t     ctrl;

	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_d;
	logic [stl_pkg::ID_COUNT-1:0] member_q;

	logic                     rsp_valid_q;
	logic [CNT_W-1:0]          rsp_count_q;
	logic                     rsp_empty_q;
	logic [stl_pkg::ID_W-1:0]  rsp_id_q;
	logic [stl_pkg::KEY_W-1:0] rsp_key_q;
	stl_pkg::status_t          rsp_status_q;

	logic             accept;
	logic             is_insert;
	logic             listed;
	logic             full;
	logic             ins_go;
	logic             del_go;
	logic             del_hit;
	stl_pkg::status_t status_d;

	// result register frees up when empty or drained this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_insert = (req.op == stl_pkg::OP_INSERT);
	assign listed    = member_q[req.entry_id];
	assign full      = (count_q == CNT_W'(NUM_ENTRIES));
	assign ins_go    = accept && is_insert && !listed && !full;
	assign del_go    = accept && !is_insert && listed;
	assign del_hit   = shift[NUM_ENTRIES];

	assign ctrl.ins_en = ins_go;
	assign ctrl.del_en = del_go;
	assign ctrl.id     = req.entry_id;
	assign ctrl.key    = req.sort_key;

	// row ends: nothing left of slot 0, an empty slot right of the last one
	assign take[0]          = 1'b0;
	assign shift[0]         = 1'b0;
	assign cur[NUM_ENTRIES] = '0;

	// take[] is shifted by one: take[i+1] is slot i's flag, fed to slot i+1
	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		stl_pkg::entry_t left_q;
		logic            take_i;

		if (i == 0) begin : g_first
			assign left_q = '0;
		end else begin : g_rest
			assign left_q = cur[i-1];
		end

		stl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_q    (left_q),
			.left_take (take[i]),
			.right_q   (cur[i+1]),
			.shift_in  (shift[i]),
			.take      (take_i),
			.shift_out (shift[i+1]),
			.cur       (cur[i]),
			.nxt       (nxt[i])
		);

		assign take[i+1] = take_i;
	end

	always_comb begin
		status_d = stl_pkg::ST_OK;
		if (is_insert) begin
			if (listed) begin
				status_d = stl_pkg::ST_LISTED;
			end else if (full) begin
				status_d = stl_pkg::ST_FULL;
			end
		end else if (!listed || !del_hit) begin
			status_d = stl_pkg::ST_NOT_LISTED;
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_go) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_go && del_hit) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			member_q <= '0;
		end else begin
			count_q <= count_d;
			if (ins_go) begin
				member_q[req.entry_id] <= 1'b1;
			end else if (accept && !is_insert) begin
				member_q[req.entry_id] <= 1'b0;
			end
		end
	end

	// result beat: hold until drained, advance on each accepted operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_count_q  <= count_d;
			rsp_empty_q  <= (count_d == '0);
			rsp_id_q     <= nxt[0].valid ? nxt[0].id : '0;
			rsp_key_q    <= nxt[0].valid ? nxt[0].key : '0;
			rsp_status_q <= status_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.list_empty  = rsp_empty_q;
	assign rsp.head_id     = rsp_id_q;
	assign rsp.head_key    = rsp_key_q;
	assign rsp.status      = rsp_status_q;

endmodule

### rtl/stl_chk.sv
// ---------------------------------------------------------------------------
// stl_chk - port checker of the sorted task list
// Watches the request and result channels of the top level.
// ---------------------------------------------------------------------------
module stl_chk #(
	parameter int unsigned NUM_ENTRIES = stl_pkg::NUM_ENTRIES_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic [$clog2(NUM_ENTRIES + 1)-1:0]   rsp_count,
	input logic                                 rsp_empty,
	input logic [stl_pkg::ID_W-1:0]             rsp_id,
	input logic [stl_pkg::KEY_W-1:0]            rsp_key
);

	localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_key))
		else $error("result beat changed while stalled");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted operation gave no result beat");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_empty == (rsp_count == '0))
		else $error("empty flag disagrees with count");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_empty |-> rsp_id == '0 && rsp_key == '0)
		else $error("head not zero on empty list");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_W'(NUM_ENTRIES))
		else $error("count above capacity");

endmodule

bind sorted_task_list_core stl_chk #(.NUM_ENTRIES(NUM_ENTRIES)) u_stl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_count (rsp.entry_count),
	.rsp_empty (rsp.list_empty),
	.rsp_id    (rsp.head_id),
	.rsp_key   (rsp.head_key)
);

### test/tb_sorted_task_list_core.sv
// ---------------------------------------------------------------------------
// tb_sorted_task_list_core - self-checking bench for the sorted task list
// Sends insert and delete beats, keeps its own shadow of the ordered list and
// compares every result beat (count, empty, head entry, status) in order.
// ---------------------------------------------------------------------------
module tb_sorted_task_list_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_DEPTH  = 16;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned RAND_OPS    = 1900;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_WAIT  = 20;
	localparam logic [stl_pkg::KEY_W-1:0] KEY_TAIL = '1;

	// one operation beat as offered on req
	typedef struct packed {
		stl_pkg::op_t              op;
		logic [stl_pkg::ID_W-1:0]  id;
		logic [stl_pkg::KEY_W-1:0] key;
	} list_op_t;

	// one result beat as expected on rsp
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		logic                      empty;
		logic [stl_pkg::ID_W-1:0]  head_id;
		logic [stl_pkg::KEY_W-1:0] head_key;
		stl_pkg::status_t          status;
	} list_result_t;

	logic clk;
	logic arst_n;

	stl_in_if                    req_if ();
	stl_out_if #(.CNT_W(CNT_W))  rsp_if ();

	sorted_task_list_core #(
		.NUM_ENTRIES(LIST_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// -----------------------------------------------------------------------
	// Clock: 10 ns period.
	// -----------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// -----------------------------------------------------------------------
	// Shadow of the list: keys and ids in list order, fill count, and the
	// per-id membership flags. Updated once per accepted operation beat.
	// -----------------------------------------------------------------------
	logic [stl_pkg::KEY_W-1:0] shadow_key [LIST_DEPTH];
	logic [stl_pkg::ID_W-1:0]  shadow_id  [LIST_DEPTH];
	logic                      shadow_listed [stl_pkg::ID_COUNT];
	int unsigned               shadow_count;

	list_op_t     ops_to_send [$];
	list_result_t results_due [$];

	int unsigned accepted_ops;
	int unsigned fail_count;
	int unsigned cycle_count;

	// Apply one operation to the shadow list and queue the result it gives.
	task automatic apply_list_op(input list_op_t it);
		int unsigned  pos;
		list_result_t res;
		begin
			res.status = stl_pkg::ST_OK;
			if (it.op == stl_pkg::OP_INSERT) begin
				if (shadow_listed[it.id]) begin
					// duplicate id wins over the full check
					res.status = stl_pkg::ST_LISTED;
				end else if (shadow_count >= LIST_DEPTH) begin
					res.status = stl_pkg::ST_FULL;
				end else begin
					// land after every entry with an equal or smaller key;
					// the all-ones key never finds a larger one and goes last
					pos = shadow_count;
					if (it.key != KEY_TAIL) begin
						for (int unsigned i = 0; i < shadow_count; i++) begin
							if (shadow_key[i] > it.key) begin
								pos = i;
								break;
							end
						end
					end
					for (int unsigned i = shadow_count; i > pos; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_id[i]  = shadow_id[i-1];
					end
					shadow_key[pos] = it.key;
					shadow_id[pos]  = it.id;
					shadow_listed[it.id] = 1'b1;
					shadow_count++;
				end
			end else begin
				if (!shadow_listed[it.id]) begin
					res.status = stl_pkg::ST_NOT_LISTED;
				end else begin
					pos = shadow_count;
					for (int unsigned i = 0; i < shadow_count; i++) begin
						if (shadow_id[i] == it.id) begin
							pos = i;
							break;
						end
					end
					// close the gap: everything behind the hole moves up one slot
					for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_id[i]  = shadow_id[i+1];
					end
					shadow_count--;
					shadow_key[shadow_count] = '0;
					shadow_id[shadow_count]  = '0;
					shadow_listed[it.id] = 1'b0;
				end
			end
			res.count    = shadow_count[CNT_W-1:0];
			res.empty    = (shadow_count == 0);
			// head reads zero on an empty list
			res.head_id  = (shadow_count > 0) ? shadow_id[0]  : '0;
			res.head_key = (shadow_count > 0) ? shadow_key[0] : '0;
			results_due.push_back(res);
		end
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		begin
			r = $urandom_range(99);
			if (quiet || r < 55)
				pick_gap = 0;
			else if (r < 85)
				pick_gap = $urandom_range(3, 1);
			else if (r < 97)
				pick_gap = $urandom_range(12, 4);
			else
				pick_gap = $urandom_range(60, 20);
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus generation. A separate membership mask, kept at generation
	// time, steers the random part toward legal inserts and deletes so the
	// list swings between empty and full many times.
	// -----------------------------------------------------------------------
	logic [stl_pkg::ID_COUNT-1:0] gen_listed;
	int unsigned                  gen_count;

	task automatic queue_op(input stl_pkg::op_t op, input logic [stl_pkg::ID_W-1:0] id,
		input logic [stl_pkg::KEY_W-1:0] key);
		list_op_t it;
		begin
			it.op  = op;
			it.id  = id;
			it.key = key;
			ops_to_send.push_back(it);
			if (op == stl_pkg::OP_INSERT && !gen_listed[id] && gen_count < LIST_DEPTH) begin
				gen_listed[id] = 1'b1;
				gen_count++;
			end else if (op == stl_pkg::OP_DELETE && gen_listed[id]) begin
				gen_listed[id] = 1'b0;
				gen_count--;
			end
		end
	endtask

	function automatic logic [stl_pkg::KEY_W-1:0] pick_key();
		int unsigned r;
		begin
			r = $urandom_range(99);
			if (r < 35)
				pick_key = $urandom;
			else if (r < 65)
				pick_key = $urandom_range(7);          // crowd keys to force ties
			else if (r < 75)
				pick_key = '0;
			else if (r < 85)
				pick_key = KEY_TAIL;
			else if (r < 92)
				pick_key = KEY_TAIL - 1;
			else
				pick_key = {1'($urandom_range(1)), 31'd0} | 32'($urandom_range(255));
		end
	endfunction

	function automatic logic [stl_pkg::ID_W-1:0] pick_id(input bit want_listed);
		logic [stl_pkg::ID_W-1:0] id;
		begin
			id = stl_pkg::ID_W'($urandom_range(stl_pkg::ID_COUNT - 1));
			while (gen_listed[id] != want_listed)
				id = stl_pkg::ID_W'($urandom_range(stl_pkg::ID_COUNT - 1));
			pick_id = id;
		end
	endfunction

	task automatic build_stimulus();
		bit          filling;
		bit          do_insert;
		int unsigned r;
		begin
			gen_listed = '0;
			gen_count  = 0;

			// directed part: empty-list cases, extremes, ties, tail key
			queue_op(stl_pkg::OP_DELETE, 4'd4,  '0);             // delete on empty list
			queue_op(stl_pkg::OP_INSERT, 4'd0,  '0);             // smallest key
			queue_op(stl_pkg::OP_INSERT, 4'd15, KEY_TAIL);       // all-ones to tail
			queue_op(stl_pkg::OP_INSERT, 4'd0,  32'd9);          // already listed
			queue_op(stl_pkg::OP_INSERT, 4'd1,  32'd5);
			queue_op(stl_pkg::OP_INSERT, 4'd2,  32'd5);          // equal key keeps order
			queue_op(stl_pkg::OP_INSERT, 4'd3,  KEY_TAIL);       // behind the other all-ones
			queue_op(stl_pkg::OP_INSERT, 4'd4,  KEY_TAIL - 1);   // just ahead of the tail keys
			queue_op(stl_pkg::OP_DELETE, 4'd0,  KEY_TAIL);       // drop the head
			queue_op(stl_pkg::OP_DELETE, 4'd9,  '0);             // not listed
			queue_op(stl_pkg::OP_DELETE, 4'd3,  '0);             // drop from the tail group
			// fill to the last slot
			queue_op(stl_pkg::OP_INSERT, 4'd0,  32'hA5A5_5A5A);
			queue_op(stl_pkg::OP_INSERT, 4'd3,  32'd5);
			for (int unsigned i = 5; i < 15; i++)
				queue_op(stl_pkg::OP_INSERT, i[stl_pkg::ID_W-1:0], $urandom_range(6, 3));
			// full list: every id is listed, so these report already listed
			queue_op(stl_pkg::OP_INSERT, 4'd7,  32'd1);
			queue_op(stl_pkg::OP_INSERT, 4'd15, '0);

			// random part
			filling = 1'b0;
			for (int unsigned n = 0; n < RAND_OPS; n++) begin
				if (gen_count == LIST_DEPTH)
					filling = 1'b0;
				else if (gen_count == 0)
					filling = 1'b1;
				r = $urandom_range(99);
				if (r < 88) begin
					do_insert = ($urandom_range(99) < 75) ? filling : !filling;
					if (do_insert && gen_count == LIST_DEPTH)
						do_insert = 1'b0;
					if (!do_insert && gen_count == 0)
						do_insert = 1'b1;
					if (do_insert)
						queue_op(stl_pkg::OP_INSERT, pick_id(1'b0), pick_key());
					else
						queue_op(stl_pkg::OP_DELETE, pick_id(1'b1), $urandom);
				end else begin
					// noise: any op, any id, any key
					queue_op(stl_pkg::op_t'($urandom_range(1)),
						stl_pkg::ID_W'($urandom_range(stl_pkg::ID_COUNT - 1)),
						pick_key());
				end
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Reset, stimulus fill and end of run.
	// -----------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.op       = 1'b0;
		req_if.entry_id = '0;
		req_if.sort_key = '0;
		rsp_if.ready    = 1'b0;
		shadow_count    = 0;
		for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
			shadow_key[i] = '0;
			shadow_id[i]  = '0;
		end
		for (int unsigned i = 0; i < stl_pkg::ID_COUNT; i++)
			shadow_listed[i] = 1'b0;
		fail_count = 0;

		build_stimulus();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last beat to go in, then for its result
		@(posedge clk);
		while (ops_to_send.size() != 0 || req_if.valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		// catch any stray beat the block might still put out
		repeat (DRAIN_WAIT) @(posedge clk);

		if (results_due.size() != 0) begin
			$error("results still outstanding at end: %0d", results_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_sorted_task_list_core: PASS");
		else
			$display("tb_sorted_task_list_core: FAIL");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Timeout: a hung handshake ends the run here.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sorted_task_list_core: FAIL");
			$finish;
		end
	end

	initial cycle_count = 0;

	// -----------------------------------------------------------------------
	// Driver: on each accepted beat, update the shadow list; when the bus is
	// free (idle or just accepted), count down the gap or present the next
	// operation. Payload is held steady while valid waits for ready.
	// -----------------------------------------------------------------------
	list_op_t    cur_op;
	int unsigned send_gap;
	bit          send_quiet;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid    <= 1'b0;
			req_if.op       <= 1'b0;
			req_if.entry_id <= '0;
			req_if.sort_key <= '0;
			send_gap        <= 0;
			send_quiet      <= 1'b0;
			accepted_ops    <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				apply_list_op(cur_op);
				accepted_ops <= accepted_ops + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (send_gap > 0) begin
					send_gap     <= send_gap - 1;
					req_if.valid <= 1'b0;
				end else if (ops_to_send.size() != 0) begin
					cur_op           = ops_to_send.pop_front();
					req_if.op        <= cur_op.op;
					req_if.entry_id  <= cur_op.id;
					req_if.sort_key  <= cur_op.key;
					req_if.valid     <= 1'b1;
					// flip into or out of a back-to-back stretch now and then
					if ($urandom_range(63) == 0)
						send_quiet <= !send_quiet;
					send_gap <= pick_gap(send_quiet);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Long hold-off: twice in the run, block the result side for a long
	// stretch while the driver keeps offering beats, so the block backs up
	// and drops ready on req.
	// -----------------------------------------------------------------------
	int unsigned hold_left;
	int unsigned holds_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && accepted_ops >= 400) ||
			(holds_done == 1 && accepted_ops >= 1300)) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: compare each accepted result beat with the oldest expectation,
	// field by field, then pick the next ready level.
	// -----------------------------------------------------------------------
	list_result_t want;
	int unsigned  stall_left;
	bit           recv_quiet;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left   <= 0;
			recv_quiet   <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (results_due.size() == 0) begin
					$error("result beat with nothing expected: count %0d status %0d",
						rsp_if.entry_count, rsp_if.status);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (rsp_if.entry_count !== want.count) begin
						$error("entry_count mismatch: expected %0d, actual %0d",
							want.count, rsp_if.entry_count);
						fail_count++;
					end
					if (rsp_if.list_empty !== want.empty) begin
						$error("list_empty mismatch: expected %0b, actual %0b",
							want.empty, rsp_if.list_empty);
						fail_count++;
					end
					if (rsp_if.head_id !== want.head_id) begin
						$error("head_id mismatch: expected %0d, actual %0d",
							want.head_id, rsp_if.head_id);
						fail_count++;
					end
					if (rsp_if.head_key !== want.head_key) begin
						$error("head_key mismatch: expected %h, actual %h",
							want.head_key, rsp_if.head_key);
						fail_count++;
					end
					if (rsp_if.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp_if.status);
						fail_count++;
					end
				end
			end
			// ready: low through the hold-off, else random stalls
			if ($urandom_range(127) == 0)
				recv_quiet <= !recv_quiet;
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if (!recv_quiet && $urandom_range(3) == 0)
					stall_left <= pick_gap(1'b0);
			end
		end
	end

endmodule
